### design/look_at_basis_matrix_unit_macros.svh
`ifndef LOOK_AT_BASIS_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_BASIS_MATRIX_UNIT_MACROS_SVH

// Checks a consequence in the same cycle as its condition.
`define LAB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its condition.
`define LAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lab_pkg.sv
package lab_pkg;

   localparam int IN_WIDTH      = 16;
   localparam int OUT_FRAC_BITS = 14;
   localparam int OUT_W         = 16;
   localparam int INNER_FRAC    = 30;
   localparam int INNER_W       = INNER_FRAC + 2;
   localparam int NORM_MSB      = 30;
   localparam int NM_W          = NORM_MSB + 1;
   localparam int PR_W          = 2 * IN_WIDTH;
   localparam int CX_W          = PR_W + 1;
   localparam int YV_W          = 2 * INNER_W;
   localparam int NV_W          = (CX_W > YV_W) ? CX_W : YV_W;
   localparam int P_W           = $clog2(NV_W);
   localparam int SQ_W          = 2 * NM_W;
   localparam int RAD_W         = SQ_W + 2;
   localparam int SQ_STEPS      = RAD_W / 2;
   localparam int ROOT_W        = SQ_STEPS;
   localparam int REM_W         = ROOT_W + 3;
   localparam int DQ_W          = INNER_FRAC + 1;
   localparam int DIV_STEPS     = DQ_W;
   localparam int DR_W          = ROOT_W + 1;
   localparam int OQ_W          = OUT_FRAC_BITS + 1;
   localparam int SAT_W         = ((OQ_W + 1 > OUT_W) ? OQ_W + 1 : OUT_W) + 1;
   localparam int NORM_LAT      = SQ_STEPS + DIV_STEPS + 8;
   localparam int SIDE_LAT      = NORM_LAT + 2;
   localparam int TOTAL_LAT     = 2 * NORM_LAT + 5;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
   localparam logic [SAT_W-1:0] POS_LIM = SAT_W'(2 ** (OUT_W - 1) - 1);
   localparam logic [SAT_W-1:0] NEG_LIM = SAT_W'(2 ** (OUT_W - 1));

   typedef struct packed {
      logic                       valid;
      logic [2:0]                 neg;
      logic [2:0][NV_W-1:0]       mag;
      logic [NV_W-1:0]            orv;
   } s1_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [2:0][NV_W-1:0]       mag;
      logic [P_W-1:0]             p;
   } s2_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [2:0][NM_W-1:0]       m;
   } s3_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [2:0][NM_W-1:0]       m;
      logic [2:0][SQ_W-1:0]       sq;
   } s4_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [2:0][NM_W-1:0]       m;
      logic [RAD_W-1:0]           rad;
      logic [REM_W-1:0]           rem;
      logic [ROOT_W-1:0]          root;
   } sq_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [ROOT_W-1:0]          s;
      logic [2:0][DR_W-1:0]       r;
      logic [2:0][DQ_W-1:0]       q;
      logic [2:0][OQ_W-1:0]       qt;
      logic [2:0][DR_W-1:0]       rt;
   } dv_type;

   typedef struct packed {
      logic                       valid;
      logic                       zero;
      logic [2:0]                 neg;
      logic [2:0][OQ_W:0]         om;
      logic [2:0][DQ_W:0]         im;
   } rd_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0][IN_WIDTH-1:0]   d;
      logic [5:0][PR_W-1:0]       pr;
   } x1_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0][IN_WIDTH-1:0]   d;
      logic [2:0][CX_W-1:0]       c;
   } x2_type;

   typedef struct packed {
      logic                       valid;
      logic [5:0][YV_W-1:0]       pr;
   } y1_type;

   typedef struct packed {
      logic                       valid;
      logic [2:0][YV_W-1:0]       c;
   } y2_type;

   typedef struct packed {
      logic                       deg;
      logic [2:0][OUT_W-1:0]      zo;
      logic [2:0][OUT_W-1:0]      xo;
   } side_type;

endpackage

### design/lab_norm.sv
module lab_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [lab_pkg::NV_W-1:0]    in_vec [3],
   output logic                               out_valid,
   output logic                               out_zero,
   output logic signed [lab_pkg::OUT_W-1:0]   out_vec [3],
   output logic signed [lab_pkg::INNER_W-1:0] out_inner [3]
);
   import lab_pkg::*;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   s3_type s3_in, s3_ff;
   s4_type s4_in, s4_ff;
   sq_type sq_in [0:SQ_STEPS];
   sq_type sq_ff [0:SQ_STEPS];
   dv_type dv_in [0:DIV_STEPS];
   dv_type dv_ff [0:DIV_STEPS];
   rd_type rd_in, rd_ff;

   logic                      valid_in, valid_ff;
   logic                      zero_in, zero_ff;
   logic signed [OUT_W-1:0]   vec_in [3];
   logic signed [OUT_W-1:0]   vec_ff [3];
   logic signed [INNER_W-1:0] inner_in [3];
   logic signed [INNER_W-1:0] inner_ff [3];

   always_comb begin
      s1_in.valid = in_valid;
      s1_in.orv   = '0;
      for (int i = 0; i < 3; i++) begin
         s1_in.neg[i] = in_vec[i][NV_W-1];
         s1_in.mag[i] = s1_in.neg[i] ? NV_W'(-in_vec[i]) : NV_W'(in_vec[i]);
         s1_in.orv    = s1_in.orv | s1_in.mag[i];
      end
   end

   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.neg   = s1_ff.neg;
      s2_in.mag   = s1_ff.mag;
      s2_in.zero  = (s1_ff.orv == '0);
      s2_in.p     = '0;
      for (int b = 0; b < NV_W; b++) begin
         if (s1_ff.orv[b]) begin
            s2_in.p = P_W'(b);
         end
      end
   end

   always_comb begin
      logic [NV_W-1:0] sh;
      s3_in.valid = s2_ff.valid;
      s3_in.zero  = s2_ff.zero;
      s3_in.neg   = s2_ff.neg;
      for (int i = 0; i < 3; i++) begin
         if (s2_ff.p >= P_W'(NORM_MSB)) begin
            sh = s2_ff.mag[i] >> (s2_ff.p - P_W'(NORM_MSB));
         end else begin
            sh = s2_ff.mag[i] << (P_W'(NORM_MSB) - s2_ff.p);
         end
         s3_in.m[i] = sh[NM_W-1:0];
      end
   end

   always_comb begin
      s4_in.valid = s3_ff.valid;
      s4_in.zero  = s3_ff.zero;
      s4_in.neg   = s3_ff.neg;
      s4_in.m     = s3_ff.m;
      for (int i = 0; i < 3; i++) begin
         s4_in.sq[i] = SQ_W'(s3_ff.m[i]) * SQ_W'(s3_ff.m[i]);
      end
   end

   always_comb begin
      sq_type            cur;
      sq_type            nxt;
      logic [REM_W-1:0]  rem2;
      logic [REM_W-1:0]  trial;
      logic              ge;
      sq_in[0].valid = s4_ff.valid;
      sq_in[0].zero  = s4_ff.zero;
      sq_in[0].neg   = s4_ff.neg;
      sq_in[0].m     = s4_ff.m;
      sq_in[0].rad   = RAD_W'(s4_ff.sq[0]) + RAD_W'(s4_ff.sq[1]) + RAD_W'(s4_ff.sq[2]);
      sq_in[0].rem   = '0;
      sq_in[0].root  = '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
         cur      = sq_ff[k];
         nxt      = cur;
         rem2     = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
         trial    = REM_W'({cur.root, 2'b01});
         ge       = (rem2 >= trial);
         nxt.rad  = {cur.rad[RAD_W-3:0], 2'b00};
         nxt.rem  = ge ? (rem2 - trial) : rem2;
         nxt.root = {cur.root[ROOT_W-2:0], ge};
         sq_in[k+1] = nxt;
      end
   end

   always_comb begin
      dv_type           cur;
      dv_type           nxt;
      logic [DR_W-1:0]  r2;
      logic             ge;
      dv_in[0].valid = sq_ff[SQ_STEPS].valid;
      dv_in[0].zero  = sq_ff[SQ_STEPS].zero;
      dv_in[0].neg   = sq_ff[SQ_STEPS].neg;
      dv_in[0].s     = sq_ff[SQ_STEPS].root;
      dv_in[0].q     = '0;
      dv_in[0].qt    = '0;
      dv_in[0].rt    = '0;
      for (int i = 0; i < 3; i++) begin
         dv_in[0].r[i] = DR_W'(sq_ff[SQ_STEPS].m[i]);
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         cur = dv_ff[k];
         nxt = cur;
         for (int i = 0; i < 3; i++) begin
            if (k == 0) begin
               r2 = cur.r[i];
            end else begin
               r2 = {cur.r[i][DR_W-2:0], 1'b0};
            end
            ge = (r2 >= DR_W'(cur.s));
            nxt.r[i] = ge ? (r2 - DR_W'(cur.s)) : r2;
            nxt.q[i] = {cur.q[i][DQ_W-2:0], ge};
            if (k == OUT_FRAC_BITS) begin
               nxt.qt[i] = nxt.q[i][OQ_W-1:0];
               nxt.rt[i] = nxt.r[i];
            end
         end
         dv_in[k+1] = nxt;
      end
   end

   always_comb begin
      logic [ROOT_W-1:0] half;
      logic              up_o;
      logic              up_i;
      half         = dv_ff[DIV_STEPS].s >> 1;
      rd_in.valid  = dv_ff[DIV_STEPS].valid;
      rd_in.zero   = dv_ff[DIV_STEPS].zero;
      rd_in.neg    = dv_ff[DIV_STEPS].neg;
      for (int i = 0; i < 3; i++) begin
         up_o = ((DR_W+1)'(dv_ff[DIV_STEPS].rt[i]) + (DR_W+1)'(half))
                >= (DR_W+1)'(dv_ff[DIV_STEPS].s);
         up_i = ((DR_W+1)'(dv_ff[DIV_STEPS].r[i]) + (DR_W+1)'(half))
                >= (DR_W+1)'(dv_ff[DIV_STEPS].s);
         rd_in.om[i] = (OQ_W+1)'(dv_ff[DIV_STEPS].qt[i]) + (OQ_W+1)'(up_o);
         rd_in.im[i] = (DQ_W+1)'(dv_ff[DIV_STEPS].q[i]) + (DQ_W+1)'(up_i);
      end
   end

   always_comb begin
      logic [SAT_W-1:0] mag;
      valid_in = rd_ff.valid;
      zero_in  = rd_ff.zero;
      for (int i = 0; i < 3; i++) begin
         mag = SAT_W'(rd_ff.om[i]);
         if (rd_ff.zero) begin
            vec_in[i]   = '0;
            inner_in[i] = '0;
         end else if (rd_ff.neg[i]) begin
            vec_in[i]   = (mag > NEG_LIM) ? OUT_MIN : OUT_W'(-mag);
            inner_in[i] = -$signed(INNER_W'(rd_ff.im[i]));
         end else begin
            vec_in[i]   = (mag > POS_LIM) ? OUT_MAX : OUT_W'(mag);
            inner_in[i] = $signed(INNER_W'(rd_ff.im[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      zero_ff  <= zero_in;
      vec_ff   <= vec_in;
      inner_ff <= inner_in;
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         for (int k = 0; k <= SQ_STEPS; k++) begin
            sq_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
         rd_ff.valid <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         sq_ff    <= sq_in;
         dv_ff    <= dv_in;
         rd_ff    <= rd_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_zero  = zero_ff;
   assign out_vec   = vec_ff;
   assign out_inner = inner_ff;

endmodule

### design/look_at_basis_matrix_unit.sv
// Look-at basis matrix unit.
// A request carries a view direction and an up vector as signed Q8.8 triples
// on the req_ ports and is taken at a rising edge where start is high and busy
// is low. Busy stays low, so a new request may be issued in every cycle.
// Each request yields one response: the x, y and z axes of the look-at
// rotation as signed Q2.14 rows on the rsp_ ports, plus a degenerate flag that
// is set when the direction, the cross product with up, or the derived y axis
// had zero length. Zero-length axes come out as all zeros.
// Each response is marked by rsp_valid for exactly one cycle, and responses
// come in request order. Throughput is one request per cycle. The path runs
// through two normalizer pipelines in series, each a 32-stage square root
// followed by a 31-stage restoring division, with two multiply and subtract
// stages for each cross product.
// The receiver cannot stall the block; it must take each response in the
// cycle that rsp_valid marks. Reset clears all valid bits, so requests in
// flight are dropped and no response follows until a new request is taken.
`include "look_at_basis_matrix_unit_macros.svh"

module look_at_basis_matrix_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_dir_x,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_dir_y,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_dir_z,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_up_x,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_up_y,
   input  logic signed [lab_pkg::IN_WIDTH-1:0]  req_up_z,
   output logic                                 rsp_valid,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_x_axis_x,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_x_axis_y,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_x_axis_z,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_y_axis_x,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_y_axis_y,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_y_axis_z,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_z_axis_x,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_z_axis_y,
   output logic signed [lab_pkg::OUT_W-1:0]     rsp_z_axis_z,
   output logic                                 rsp_degenerate
);
   import lab_pkg::*;

   x1_type x1_in, x1_ff;
   x2_type x2_in, x2_ff;
   y1_type y1_in, y1_ff;
   y2_type y2_in, y2_ff;

   logic signed [NV_W-1:0]    vec_a [3];
   logic signed [NV_W-1:0]    vec_b [3];
   logic signed [NV_W-1:0]    vec_c [3];
   logic                      a_valid, a_zero, b_valid, b_zero, c_valid, c_zero;
   logic signed [OUT_W-1:0]   zo [3];
   logic signed [OUT_W-1:0]   xo [3];
   logic signed [OUT_W-1:0]   yo [3];
   logic signed [INNER_W-1:0] zi [3];
   logic signed [INNER_W-1:0] xi [3];

   side_type side_in;
   side_type dly_ff [0:SIDE_LAT-1];

   logic                      rsp_valid_in, rsp_valid_ff;
   logic                      deg_in, deg_ff;
   logic signed [OUT_W-1:0]   xa_in [3];
   logic signed [OUT_W-1:0]   ya_in [3];
   logic signed [OUT_W-1:0]   za_in [3];
   logic signed [OUT_W-1:0]   xa_ff [3];
   logic signed [OUT_W-1:0]   ya_ff [3];
   logic signed [OUT_W-1:0]   za_ff [3];

   assign busy = 1'b0;

   always_comb begin
      x1_in.valid = start && !busy;
      x1_in.d[0]  = req_dir_x;
      x1_in.d[1]  = req_dir_y;
      x1_in.d[2]  = req_dir_z;
      x1_in.pr[0] = PR_W'(req_dir_y) * PR_W'(req_up_z);
      x1_in.pr[1] = PR_W'(req_dir_z) * PR_W'(req_up_y);
      x1_in.pr[2] = PR_W'(req_dir_z) * PR_W'(req_up_x);
      x1_in.pr[3] = PR_W'(req_dir_x) * PR_W'(req_up_z);
      x1_in.pr[4] = PR_W'(req_dir_x) * PR_W'(req_up_y);
      x1_in.pr[5] = PR_W'(req_dir_y) * PR_W'(req_up_x);
   end

   always_comb begin
      x2_in.valid = x1_ff.valid;
      x2_in.d     = x1_ff.d;
      for (int i = 0; i < 3; i++) begin
         x2_in.c[i] = CX_W'($signed(x1_ff.pr[2*i])) - CX_W'($signed(x1_ff.pr[2*i+1]));
      end
      for (int i = 0; i < 3; i++) begin
         vec_a[i] = NV_W'($signed(x2_ff.d[i]));
         vec_b[i] = NV_W'($signed(x2_ff.c[i]));
      end
   end

   lab_norm u_norm_dir (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x2_ff.valid),
      .in_vec    (vec_a),
      .out_valid (a_valid),
      .out_zero  (a_zero),
      .out_vec   (zo),
      .out_inner (zi)
   );

   lab_norm u_norm_side (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (x2_ff.valid),
      .in_vec    (vec_b),
      .out_valid (b_valid),
      .out_zero  (b_zero),
      .out_vec   (xo),
      .out_inner (xi)
   );

   always_comb begin
      y1_in.valid = a_valid && b_valid;
      y1_in.pr[0] = YV_W'(xi[1]) * YV_W'(zi[2]);
      y1_in.pr[1] = YV_W'(xi[2]) * YV_W'(zi[1]);
      y1_in.pr[2] = YV_W'(xi[2]) * YV_W'(zi[0]);
      y1_in.pr[3] = YV_W'(xi[0]) * YV_W'(zi[2]);
      y1_in.pr[4] = YV_W'(xi[0]) * YV_W'(zi[1]);
      y1_in.pr[5] = YV_W'(xi[1]) * YV_W'(zi[0]);
      y2_in.valid = y1_ff.valid;
      for (int i = 0; i < 3; i++) begin
         y2_in.c[i] = y1_ff.pr[2*i] - y1_ff.pr[2*i+1];
         vec_c[i]   = NV_W'($signed(y2_ff.c[i]));
      end
      side_in.deg = a_zero || b_zero;
      for (int i = 0; i < 3; i++) begin
         side_in.zo[i] = zo[i];
         side_in.xo[i] = xo[i];
      end
   end

   lab_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (y2_ff.valid),
      .in_vec    (vec_c),
      .out_valid (c_valid),
      .out_zero  (c_zero),
      .out_vec   (yo),
      .out_inner ()
   );

   always_comb begin
      rsp_valid_in = c_valid;
      deg_in       = dly_ff[SIDE_LAT-1].deg || c_zero;
      for (int i = 0; i < 3; i++) begin
         xa_in[i] = $signed(dly_ff[SIDE_LAT-1].xo[i]);
         ya_in[i] = yo[i];
         za_in[i] = $signed(dly_ff[SIDE_LAT-1].zo[i]);
      end
   end

   always_ff @(posedge clock) begin
      dly_ff[0] <= side_in;
      for (int k = 1; k < SIDE_LAT; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
      deg_ff <= deg_in;
      xa_ff  <= xa_in;
      ya_ff  <= ya_in;
      za_ff  <= za_in;
      if (reset) begin
         x1_ff.valid  <= 1'b0;
         x2_ff.valid  <= 1'b0;
         y1_ff.valid  <= 1'b0;
         y2_ff.valid  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_degenerate = deg_ff;
   assign rsp_x_axis_x   = xa_ff[0];
   assign rsp_x_axis_y   = xa_ff[1];
   assign rsp_x_axis_z   = xa_ff[2];
   assign rsp_y_axis_x   = ya_ff[0];
   assign rsp_y_axis_y   = ya_ff[1];
   assign rsp_y_axis_z   = ya_ff[2];
   assign rsp_z_axis_x   = za_ff[0];
   assign rsp_z_axis_y   = za_ff[1];
   assign rsp_z_axis_z   = za_ff[2];

   `LAB_ASSERT_NEXT(a_request_enters, start && !busy, x1_ff.valid,
                    "request not taken in")
   `LAB_ASSERT_NOW(a_response_has_request, rsp_valid,
                   $past(start && !busy, TOTAL_LAT), "response without request")
   `LAB_ASSERT_NOW(a_valid_dir_nonzero, rsp_valid && !rsp_degenerate,
                   rsp_z_axis_x != 0 || rsp_z_axis_y != 0 || rsp_z_axis_z != 0,
                   "zero z axis without degenerate flag")
   `LAB_ASSERT_NOW(a_zero_dir_all_zero,
                   rsp_valid && rsp_z_axis_x == 0 && rsp_z_axis_y == 0 && rsp_z_axis_z == 0,
                   rsp_x_axis_x == 0 && rsp_x_axis_y == 0 && rsp_x_axis_z == 0
                   && rsp_degenerate,
                   "zero direction gave a nonzero x axis")

endmodule

### dv/look_at_basis_matrix_unit_test.sv
`timescale 1ns / 1ps

module look_at_basis_matrix_unit_test;
   import lab_pkg::*;

   typedef struct {
      logic signed [IN_WIDTH-1:0] dir [3];
      logic signed [IN_WIDTH-1:0] up [3];
   } request_type;

   typedef struct {
      logic signed [OUT_W-1:0] axis [9];
      logic                    degenerate;
   } basis_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [IN_WIDTH-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [IN_WIDTH-1:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic rsp_valid, rsp_degenerate;
   logic signed [OUT_W-1:0] rsp_x_axis_x, rsp_x_axis_y, rsp_x_axis_z;
   logic signed [OUT_W-1:0] rsp_y_axis_x, rsp_y_axis_y, rsp_y_axis_z;
   logic signed [OUT_W-1:0] rsp_z_axis_x, rsp_z_axis_y, rsp_z_axis_z;

   request_type pending_requests [$];
   basis_type   expected_bases [$];
   int          error_count = 0;
   int          checked_count = 0;
   int          degenerate_count = 0;
   int          gap_cycles = 0;
   bit          driver_done = 1'b0;

   look_at_basis_matrix_unit u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= root + bit_val) begin
            n -= root + bit_val;
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   function automatic bit unit_vector(input longint v [3], input int frac,
                                      output longint r [3]);
      longint unsigned mag [3];
      longint unsigned peak, len2, s, q;
      peak = 0;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i] < 0 ? -v[i] : v[i];
         if (mag[i] > peak) peak = mag[i];
         r[i] = 0;
      end
      if (peak == 0) return 1'b0;
      while (peak >= (64'd1 << 31)) begin
         peak >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (peak < (64'd1 << 30)) begin
         peak <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) len2 += mag[i] * mag[i];
      s = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << frac) + (s >> 1)) / s;
         r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic void cross_product(input longint a [3], input longint b [3],
                                         output longint c [3]);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic logic signed [OUT_W-1:0] saturate(longint v);
      if (v > longint'(OUT_MAX)) return OUT_MAX;
      if (v < longint'(OUT_MIN)) return OUT_MIN;
      return v[OUT_W-1:0];
   endfunction

   function automatic basis_type look_at_basis(request_type rq);
      basis_type b;
      longint d [3], u [3], c [3], yv [3];
      longint zo [3], xo [3], yo [3], zi [3], xi [3];
      bit ok;
      for (int i = 0; i < 3; i++) begin
         d[i] = rq.dir[i];
         u[i] = rq.up[i];
      end
      ok = unit_vector(d, OUT_FRAC_BITS, zo);
      void'(unit_vector(d, INNER_FRAC, zi));
      cross_product(d, u, c);
      if (!unit_vector(c, OUT_FRAC_BITS, xo)) ok = 1'b0;
      void'(unit_vector(c, INNER_FRAC, xi));
      cross_product(xi, zi, yv);
      if (!unit_vector(yv, OUT_FRAC_BITS, yo)) ok = 1'b0;
      for (int i = 0; i < 3; i++) begin
         b.axis[i] = saturate(xo[i]);
         b.axis[3 + i] = saturate(yo[i]);
         b.axis[6 + i] = saturate(zo[i]);
      end
      b.degenerate = !ok;
      return b;
   endfunction

   function automatic void add_request(int dx, int dy, int dz, int ux, int uy, int uz);
      request_type rq;
      rq.dir[0] = IN_WIDTH'(dx); rq.dir[1] = IN_WIDTH'(dy); rq.dir[2] = IN_WIDTH'(dz);
      rq.up[0] = IN_WIDTH'(ux); rq.up[1] = IN_WIDTH'(uy); rq.up[2] = IN_WIDTH'(uz);
      pending_requests.push_back(rq);
   endfunction

   function automatic logic signed [IN_WIDTH-1:0] random_component(int mode);
      case (mode)
         0: return IN_WIDTH'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
         default: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      endcase
   endfunction

   initial begin
      request_type rq;
      int k, mode;
      add_request(256, 0, 0, 0, 256, 0);
      add_request(0, 0, -256, 0, 256, 0);
      add_request(0, 0, 0, 0, 256, 0);
      add_request(256, 256, 256, 0, 0, 0);
      add_request(256, 0, 0, 512, 0, 0);
      add_request(256, 0, 0, -768, 0, 0);
      add_request(32767, 32767, 32767, -32768, -32768, -32768);
      add_request(-32768, -32768, -32768, 32767, 0, 0);
      add_request(32767, -32768, 1, -1, 32767, -32768);
      add_request(-32768, 0, 0, 0, 0, 32767);
      add_request(1, 0, 0, 0, 1, 0);
      add_request(1, 1, 1, -1, 1, 0);
      add_request(-1, -1, -1, 0, 0, 0);
      add_request(0, 0, 0, 0, 0, 0);
      add_request(-1, 0, 0, 0, 0, 0);
      add_request(12345, -23456, 345, -4567, 5678, -32768);
      add_request(0, 32767, 0, 0, 0, -32768);
      for (int n = 0; n < 650; n++) begin
         mode = $urandom_range(0, 3);
         for (int i = 0; i < 3; i++) begin
            rq.dir[i] = random_component(mode);
            rq.up[i] = random_component($urandom_range(0, 3));
         end
         k = $urandom_range(0, 19);
         if (k == 0) begin
            for (int i = 0; i < 3; i++) rq.up[i] = rq.dir[i] * $signed(2'($urandom_range(0, 3)));
         end else if (k == 1) begin
            for (int i = 0; i < 3; i++) rq.dir[i] = '0;
         end else if (k == 2) begin
            for (int i = 0; i < 3; i++) rq.up[i] = '0;
         end
         pending_requests.push_back(rq);
      end
   end

   always @(negedge clock) begin
      if (!reset && !driver_done && !(start && busy)) begin
         if (gap_cycles > 0) begin
            start <= 1'b0;
            gap_cycles <= gap_cycles - 1;
         end else if (pending_requests.size() != 0) begin
            request_type rq;
            rq = pending_requests.pop_front();
            expected_bases.push_back(look_at_basis(rq));
            req_dir_x <= rq.dir[0]; req_dir_y <= rq.dir[1]; req_dir_z <= rq.dir[2];
            req_up_x <= rq.up[0]; req_up_y <= rq.up[1]; req_up_z <= rq.up[2];
            start <= 1'b1;
            gap_cycles <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         end else begin
            start <= 1'b0;
            driver_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         logic signed [OUT_W-1:0] actual [9];
         basis_type b;
         actual = '{rsp_x_axis_x, rsp_x_axis_y, rsp_x_axis_z,
                    rsp_y_axis_x, rsp_y_axis_y, rsp_y_axis_z,
                    rsp_z_axis_x, rsp_z_axis_y, rsp_z_axis_z};
         if (expected_bases.size() == 0) begin
            $display("%0t: unexpected response", $time);
            error_count++;
         end else begin
            b = expected_bases.pop_front();
            checked_count++;
            if (b.degenerate) degenerate_count++;
            for (int i = 0; i < 9; i++) begin
               if (actual[i] !== b.axis[i]) begin
                  $display("%0t: axis entry %0d expected %0d actual %0d",
                           $time, i, b.axis[i], actual[i]);
                  error_count++;
               end
            end
            if (rsp_degenerate !== b.degenerate) begin
               $display("%0t: degenerate expected %0b actual %0b",
                        $time, b.degenerate, rsp_degenerate);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (driver_done && expected_bases.size() == 0);
      repeat (TOTAL_LAT + 20) @(posedge clock);
      $display("Checked %0d requests, %0d of them with a degenerate basis.",
               checked_count, degenerate_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
